// ===== rtl/rawh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rawh_pkg;

	// Width of the doubled area result and of the output word.
	localparam int AREA_W = 60;
	localparam int OUT_W  = 64;

	// Signed width of the loop accumulator: holds +/-(2^60-1) plus one edge term.
	localparam int ACC_W = 62;

	// Largest doubled area; accumulators clamp here.
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((64'd1 << AREA_W) - 64'd1);
	localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

	// Per-vertex control that travels down the pipeline with each word.
	typedef struct packed {
		logic edge_en;   // vertex adds an edge from the previous vertex
		logic close_en;  // loop closes with three or more vertices
		logic loop_done; // vertex ends its loop
		logic reg_done;  // vertex ends its region
		logic sat;       // saturation already seen for this vertex
	} rawh_flags_t;

endpackage

`default_nettype wire

// ===== rtl/region_area_with_holes.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata                         tuser         tlast
// s_*      in   x_coord, y_coord (vertex)     loop_end      region_end
// m_*      out  area_doubled (60b, 0-padded)  saturated     -
//
// One vertex word is accepted every cycle while s_tready is high. A region result is valid
// in the output register after its last vertex has passed the input, product, term, loop
// accumulator, closing edge, absolute value and hole total registers.
// Reset clears all loop and region state; the next vertex starts a new outer loop.
// When the output is stalled, vertex words keep flowing while one region result waits
// in the output register and one in the stage before it; the next region end stalls.
module region_area_with_holes #(
	parameter int COORD_BITS        = 24,
	parameter int MAX_LOOP_VERTICES = 4096,
	localparam int TDATA_W          = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output      logic                        s_tready,
	input  wire logic [TDATA_W-1:0]          s_tdata,  // x_coord, y_coord, zero pad
	input  wire logic                        s_tuser,  // loop_end
	input  wire logic                        s_tlast,  // region_end
	output      logic                        m_tvalid,
	input  wire logic                        m_tready,
	output      logic [rawh_pkg::OUT_W-1:0]  m_tdata,  // area_doubled, zero pad
	output      logic                        m_tuser   // saturated
);

	import rawh_pkg::*;

	localparam int CW  = COORD_BITS;
	localparam int PW  = 2 * CW;
	localparam int TW  = PW + 1;
	localparam int VCW = $clog2(MAX_LOOP_VERTICES + 1);

	// Loop tracking state at the input.
	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [VCW-1:0]       vert_count_q;
	logic                 loop_open_q;

	// Pipeline valids and stage moves.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic mv1, mv2, mv3, mv4, mv5, mv6, mv7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	// Stage payloads.
	rawh_flags_t          fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6;
	logic signed [CW-1:0] e_ax_s1, e_ay_s1, e_bx_s1, e_by_s1;
	logic signed [CW-1:0] c_ax_s1, c_ay_s1, c_bx_s1, c_by_s1;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [TW-1:0] t_edge_s3, t_close_s3, t_close_s4;
	logic signed [ACC_W-1:0] acc_s4, c_s5;
	logic [AREA_W-1:0]    mag_s6;
	logic [AREA_W-1:0]    outer_s7, holes_s7;
	logic                 sat_s7;

	// Region state.
	logic signed [ACC_W-1:0] loop_sum_q;
	logic [AREA_W-1:0]    outer_q, holes_q;
	logic                 on_outer_q, sat_seen_q;

	// Handshake chain: a stage moves when the stage after it can take the word.
	assign mv7  = vld_s7 && (!m_tvalid || m_tready);
	assign rdy7 = !vld_s7 || mv7;
	assign mv6  = vld_s6 && (!fl_s6.reg_done || rdy7);
	assign rdy6 = !vld_s6 || mv6;
	assign mv5  = vld_s5 && rdy6;
	assign rdy5 = !vld_s5 || mv5;
	assign mv4  = vld_s4 && rdy5;
	assign rdy4 = !vld_s4 || mv4;
	assign mv3  = vld_s3 && rdy4;
	assign rdy3 = !vld_s3 || mv3;
	assign mv2  = vld_s2 && rdy3;
	assign rdy2 = !vld_s2 || mv2;
	assign mv1  = vld_s1 && rdy2;
	assign rdy1 = !vld_s1 || mv1;
	assign s_tready = rdy1;

	// Input vertex decode and loop bookkeeping.
	logic signed [CW-1:0] x_in, y_in, first_x_nx, first_y_nx, prev_x_nx, prev_y_nx;
	logic [VCW-1:0]       vc_nx;
	logic                 in_fire, take, closing;

	always_comb begin
		x_in       = s_tdata[CW-1:0];
		y_in       = s_tdata[2*CW-1:CW];
		in_fire    = s_tvalid && rdy1;
		take       = vert_count_q < VCW'(MAX_LOOP_VERTICES);
		closing    = s_tuser || s_tlast;
		first_x_nx = (take && !loop_open_q) ? x_in : first_x_q;
		first_y_nx = (take && !loop_open_q) ? y_in : first_y_q;
		prev_x_nx  = take ? x_in : prev_x_q;
		prev_y_nx  = take ? y_in : prev_y_q;
		vc_nx      = take ? vert_count_q + VCW'(1) : vert_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			vert_count_q <= '0;
			loop_open_q  <= 1'b0;
		end else if (in_fire) begin
			if (closing) begin
				first_x_q    <= '0;
				first_y_q    <= '0;
				prev_x_q     <= '0;
				prev_y_q     <= '0;
				vert_count_q <= '0;
				loop_open_q  <= 1'b0;
			end else begin
				first_x_q    <= first_x_nx;
				first_y_q    <= first_y_nx;
				prev_x_q     <= prev_x_nx;
				prev_y_q     <= prev_y_nx;
				vert_count_q <= vc_nx;
				loop_open_q  <= loop_open_q || take;
			end
		end
	end

	// Stage 1: edge endpoints and flags.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			e_ax_s1 <= prev_x_q;
			e_ay_s1 <= prev_y_q;
			e_bx_s1 <= x_in;
			e_by_s1 <= y_in;
			c_ax_s1 <= prev_x_nx;
			c_ay_s1 <= prev_y_nx;
			c_bx_s1 <= first_x_nx;
			c_by_s1 <= first_y_nx;
			fl_s1.edge_en   <= take && loop_open_q;
			fl_s1.close_en  <= closing && (vc_nx >= VCW'(3));
			fl_s1.loop_done <= closing;
			fl_s1.reg_done  <= s_tlast;
			fl_s1.sat       <= !take;
		end
	end

	// Stage 2: the four cross products.
	always_ff @(posedge clk) begin
		if (rdy2) begin
			p0_s2 <= e_ax_s1 * e_by_s1;
			p1_s2 <= e_bx_s1 * e_ay_s1;
			p2_s2 <= c_ax_s1 * c_by_s1;
			p3_s2 <= c_bx_s1 * c_ay_s1;
			fl_s2 <= fl_s1;
		end
	end

	// Stage 3: shoelace terms for the edge and the closing edge.
	always_ff @(posedge clk) begin
		if (rdy3) begin
			t_edge_s3  <= fl_s2.edge_en ?
				({p0_s2[PW-1], p0_s2} - {p1_s2[PW-1], p1_s2}) : '0;
			t_close_s3 <= {p2_s2[PW-1], p2_s2} - {p3_s2[PW-1], p3_s2};
			fl_s3      <= fl_s2;
		end
	end

	// Stage 4: loop accumulator with clamping.
	logic signed [ACC_W-1:0] edge_sum, edge_acc;
	logic                    edge_clamp;
	rawh_flags_t             fl4_nx;

	always_comb begin
		edge_sum   = loop_sum_q + {{(ACC_W-TW){t_edge_s3[TW-1]}}, t_edge_s3};
		edge_acc   = edge_sum;
		edge_clamp = 1'b0;
		if (edge_sum > ACC_MAX) begin
			edge_acc   = ACC_MAX;
			edge_clamp = 1'b1;
		end else if (edge_sum < ACC_MIN) begin
			edge_acc   = ACC_MIN;
			edge_clamp = 1'b1;
		end
		fl4_nx     = fl_s3;
		fl4_nx.sat = fl_s3.sat || edge_clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_sum_q <= '0;
		end else if (mv3) begin
			loop_sum_q <= fl_s3.loop_done ? '0 : edge_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			acc_s4     <= edge_acc;
			t_close_s4 <= t_close_s3;
			fl_s4      <= fl4_nx;
		end
	end

	// Stage 5: closing edge, clamped.
	logic signed [ACC_W-1:0] close_sum, close_acc;
	logic                    close_clamp;
	rawh_flags_t             fl5_nx;

	always_comb begin
		close_sum   = acc_s4 + {{(ACC_W-TW){t_close_s4[TW-1]}}, t_close_s4};
		close_acc   = close_sum;
		close_clamp = 1'b0;
		if (close_sum > ACC_MAX) begin
			close_acc   = ACC_MAX;
			close_clamp = 1'b1;
		end else if (close_sum < ACC_MIN) begin
			close_acc   = ACC_MIN;
			close_clamp = 1'b1;
		end
		fl5_nx     = fl_s4;
		fl5_nx.sat = fl_s4.sat || (fl_s4.close_en && close_clamp);
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			c_s5  <= fl_s4.close_en ? close_acc : '0;
			fl_s5 <= fl5_nx;
		end
	end

	// Stage 6: loop magnitude.
	logic signed [ACC_W-1:0] c_neg;

	assign c_neg = -c_s5;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			mag_s6 <= c_s5[ACC_W-1] ? c_neg[AREA_W-1:0] : c_s5[AREA_W-1:0];
			fl_s6  <= fl_s5;
		end
	end

	// Stage 7: outer value and hole total for the region.
	logic [AREA_W:0]   hole_sum;
	logic [AREA_W-1:0] outer_nx, holes_nx;
	logic              on_outer_nx, sat_nx;

	always_comb begin
		hole_sum    = {1'b0, holes_q} + {1'b0, mag_s6};
		outer_nx    = outer_q;
		holes_nx    = holes_q;
		on_outer_nx = on_outer_q;
		sat_nx      = sat_seen_q || fl_s6.sat;
		if (fl_s6.loop_done) begin
			if (on_outer_q) begin
				outer_nx    = mag_s6;
				on_outer_nx = 1'b0;
			end else if (hole_sum[AREA_W]) begin
				holes_nx = '1;
				sat_nx   = 1'b1;
			end else begin
				holes_nx = hole_sum[AREA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q    <= '0;
			holes_q    <= '0;
			on_outer_q <= 1'b1;
			sat_seen_q <= 1'b0;
		end else if (mv6) begin
			if (fl_s6.reg_done) begin
				outer_q    <= '0;
				holes_q    <= '0;
				on_outer_q <= 1'b1;
				sat_seen_q <= 1'b0;
			end else begin
				outer_q    <= outer_nx;
				holes_q    <= holes_nx;
				on_outer_q <= on_outer_nx;
				sat_seen_q <= sat_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy7) begin
			outer_s7 <= outer_nx;
			holes_s7 <= holes_nx;
			sat_s7   <= sat_nx;
		end
	end

	// Output register: outer minus holes, clamped at zero.
	logic [AREA_W:0] area_diff;

	assign area_diff = {1'b0, outer_s7} - {1'b0, holes_s7};

	always_ff @(posedge clk) begin
		if (!m_tvalid || m_tready) begin
			m_tdata <= {{(OUT_W-AREA_W){1'b0}},
				(area_diff[AREA_W] ? {AREA_W{1'b0}} : area_diff[AREA_W-1:0])};
			m_tuser <= sat_s7;
		end
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			vld_s7   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= mv1;
			if (rdy3) vld_s3 <= mv2;
			if (rdy4) vld_s4 <= mv3;
			if (rdy5) vld_s5 <= mv4;
			if (rdy6) vld_s6 <= mv5;
			if (rdy7) vld_s7 <= mv6 && fl_s6.reg_done;
			if (!m_tvalid || m_tready) m_tvalid <= mv7;
		end
	end

endmodule

`default_nettype wire
